// ===== hw/rtl/ufbs_pkg.sv =====
// ufbs_pkg: request/response beat types, request codes and controller states
// for the union-find by size engine. no dependencies.

package ufbs_pkg;

	localparam int ID_W = 11;

	localparam logic REQ_MERGE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] node_a;
		logic [ID_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] root_of_a;
		logic [ID_W-1:0] root_of_b;
		logic            were_together;
		logic            merged;
		logic [ID_W-1:0] set_size;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_A,
		ST_WALK_B,
		ST_DECIDE,
		ST_WRITE2
	} state_t;

endpackage

// ===== hw/rtl/ufbs_store.sv =====
// ufbs_store: single-port-write, single-port-read synchronous memory holding
// the parent/size entries. read data is registered.
// no package dependencies.

module ufbs_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int EW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	logic [EW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/union_find_by_size_unit.sv =====
// union_find_by_size_unit: disjoint-set engine, union by size, no path
// compression. uses ufbs_pkg and ufbs_store.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+---------------------------------------
//  request   | start, busy, req        | beat taken when start && !busy
//  response  | done, rsp               | one-cycle strobe, cannot be held off
//
// after reset the store is swept to -1, one entry a cycle, and busy stays
// high until the sweep is done. a request then walks node_a to its root,
// walks node_b to its root and decides, with an extra write step on a
// merge; every find step is one read of the store (depth = links walked,
// at most log2(NODE_COUNT)). an out-of-range id skips its walk. done rises
// the cycle busy drops, and a new request may be taken in that same cycle.

module union_find_by_size_unit #(
	parameter int NODE_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ufbs_pkg::req_t     req,
	output logic               done,
	output ufbs_pkg::rsp_t     rsp
);

	localparam int ID_W = ufbs_pkg::ID_W;
	localparam int AW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int EW   = $clog2(NODE_COUNT + 1) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);
	localparam logic [EW-1:0] N_E       = EW'(NODE_COUNT);
	localparam logic [EW-1:0] MINUS_ONE = '1;

	function automatic logic id_ok(input logic [ID_W-1:0] id);
		return (id != '0) && (32'(id) <= 32'(NODE_COUNT));
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] id);
		logic [ID_W-1:0] m;
		m = id - 1'b1;
		return AW'(m);
	endfunction

	ufbs_pkg::state_t state_q, state_d;
	logic [AW-1:0]       clr_q, clr_d;
	ufbs_pkg::req_t      req_q, req_d;
	logic [ID_W-1:0]     cur_q, cur_d;
	logic [ID_W-1:0]     ra_q, ra_d, rb_q, rb_d;
	logic signed [EW-1:0] ea_q, ea_d, eb_q, eb_d;
	logic [AW-1:0]       w2_addr_q, w2_addr_d;
	logic [EW-1:0]       w2_data_q, w2_data_d;
	ufbs_pkg::rsp_t      rsp_q, rsp_d;
	logic                done_q, done_d;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	ufbs_store #(
		.DEPTH (NODE_COUNT),
		.AW    (AW),
		.EW    (EW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// entry seen on the current walk step
	logic signed [EW-1:0] e;
	logic                 e_link;
	logic                 va, vb, together, do_merge, a_small;
	logic signed [EW-1:0] sum;
	logic [EW-1:0]        neg_sum, neg_ea;

	assign e        = $signed(mem_rdata);
	assign e_link   = !mem_rdata[EW-1] && (mem_rdata != '0) && (mem_rdata <= N_E);
	assign va       = id_ok(req_q.node_a);
	assign vb       = id_ok(req_q.node_b);
	assign together = (ra_q == rb_q);
	assign do_merge = (req_q.req_type == ufbs_pkg::REQ_MERGE) && !together && va && vb;
	assign a_small  = (ea_q > eb_q);
	assign sum      = ea_q + eb_q;
	assign neg_sum  = $unsigned(-sum);
	assign neg_ea   = $unsigned(-ea_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufbs_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		cur_q     <= cur_d;
		ra_q      <= ra_d;
		rb_q      <= rb_d;
		ea_q      <= ea_d;
		eb_q      <= eb_d;
		w2_addr_q <= w2_addr_d;
		w2_data_q <= w2_data_d;
		rsp_q     <= rsp_d;
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		req_d     = req_q;
		cur_d     = cur_q;
		ra_d      = ra_q;
		rb_d      = rb_q;
		ea_d      = ea_q;
		eb_d      = eb_q;
		w2_addr_d = w2_addr_q;
		w2_data_d = w2_data_q;
		rsp_d     = rsp_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = MINUS_ONE;
		mem_re    = 1'b0;
		mem_raddr = to_addr(cur_q);
		case (state_q)
			ufbs_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == LAST_ADDR) begin
					clr_d   = '0;
					state_d = ufbs_pkg::ST_IDLE;
				end
			end
			ufbs_pkg::ST_IDLE: begin
				if (start) begin
					req_d = req;
					if (id_ok(req.node_a)) begin
						cur_d     = req.node_a;
						mem_re    = 1'b1;
						mem_raddr = to_addr(req.node_a);
						state_d   = ufbs_pkg::ST_WALK_A;
					end else begin
						ra_d = req.node_a;
						if (id_ok(req.node_b)) begin
							cur_d     = req.node_b;
							mem_re    = 1'b1;
							mem_raddr = to_addr(req.node_b);
							state_d   = ufbs_pkg::ST_WALK_B;
						end else begin
							rb_d    = req.node_b;
							state_d = ufbs_pkg::ST_DECIDE;
						end
					end
				end
			end
			ufbs_pkg::ST_WALK_A: begin
				if (e_link) begin
					cur_d     = ID_W'(mem_rdata);
					mem_re    = 1'b1;
					mem_raddr = to_addr(ID_W'(mem_rdata));
				end else begin
					ra_d = cur_q;
					ea_d = e;
					if (vb) begin
						cur_d     = req_q.node_b;
						mem_re    = 1'b1;
						mem_raddr = to_addr(req_q.node_b);
						state_d   = ufbs_pkg::ST_WALK_B;
					end else begin
						rb_d    = req_q.node_b;
						state_d = ufbs_pkg::ST_DECIDE;
					end
				end
			end
			ufbs_pkg::ST_WALK_B: begin
				if (e_link) begin
					cur_d     = ID_W'(mem_rdata);
					mem_re    = 1'b1;
					mem_raddr = to_addr(ID_W'(mem_rdata));
				end else begin
					rb_d    = cur_q;
					eb_d    = e;
					state_d = ufbs_pkg::ST_DECIDE;
				end
			end
			ufbs_pkg::ST_DECIDE: begin
				rsp_d.root_of_a     = ra_q;
				rsp_d.root_of_b     = rb_q;
				rsp_d.were_together = together;
				rsp_d.merged        = do_merge;
				if (!va || !ea_q[EW-1]) begin
					rsp_d.set_size = ID_W'(1);
				end else begin
					rsp_d.set_size = ID_W'(neg_ea);
				end
				if (do_merge) begin
					// first write: the new root takes the combined size
					mem_we         = 1'b1;
					mem_wdata      = $unsigned(sum);
					rsp_d.set_size = ID_W'(neg_sum);
					if (a_small) begin
						mem_waddr        = to_addr(rb_q);
						w2_addr_d        = to_addr(ra_q);
						w2_data_d        = EW'(rb_q);
						rsp_d.root_of_a  = rb_q;
					end else begin
						mem_waddr        = to_addr(ra_q);
						w2_addr_d        = to_addr(rb_q);
						w2_data_d        = EW'(ra_q);
						rsp_d.root_of_b  = ra_q;
					end
					state_d = ufbs_pkg::ST_WRITE2;
				end else begin
					done_d  = 1'b1;
					state_d = ufbs_pkg::ST_IDLE;
				end
			end
			ufbs_pkg::ST_WRITE2: begin
				// second write: the old root points at the new one
				mem_we    = 1'b1;
				mem_waddr = w2_addr_q;
				mem_wdata = w2_data_q;
				done_d    = 1'b1;
				state_d   = ufbs_pkg::ST_IDLE;
			end
			default: begin
				state_d = ufbs_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ufbs_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hw/rtl/ufbs_checker.sv =====
// ufbs_checker: port-level checks for union_find_by_size_unit, attached by
// the bind at the end of this file. uses ufbs_pkg.

module ufbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ufbs_pkg::rsp_t rsp
);

	a_done_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while engine busy");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request beat taken but engine not busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without preceding work");

	a_merge_roots: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.merged |-> (rsp.root_of_a == rsp.root_of_b) && !rsp.were_together)
		else $error("merge reported with split roots or prior membership");

	a_together_roots: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.were_together |-> (rsp.root_of_a == rsp.root_of_b) && !rsp.merged)
		else $error("same-set result with differing roots or a merge");

endmodule

bind union_find_by_size_unit ufbs_checker u_ufbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
